// ===== hw/rtl/nsfp_pkg.sv =====
`default_nettype none
package nsfp_pkg;

  localparam int MAX_FRAC_DIGITS = 5;
  localparam int MAX_FIELD_INDEX = 31;
  localparam int HDR_LEN = 5;

  localparam logic [2:0] KIND_GSV   = 3'd0;
  localparam logic [2:0] KIND_GGA   = 3'd1;
  localparam logic [2:0] KIND_GSA   = 3'd2;
  localparam logic [2:0] KIND_RMC   = 3'd3;
  localparam logic [2:0] KIND_VTG   = 3'd4;
  localparam logic [2:0] KIND_OTHER = 3'd5;

  // header letters, first letter in the top byte
  localparam logic [39:0] HDR_GPGSV = 40'h47_50_47_53_56;
  localparam logic [39:0] HDR_GPGGA = 40'h47_50_47_47_41;
  localparam logic [39:0] HDR_GPGSA = 40'h47_50_47_53_41;
  localparam logic [39:0] HDR_GPRMC = 40'h47_50_52_4D_43;
  localparam logic [39:0] HDR_GPVTG = 40'h47_50_56_54_47;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  typedef struct packed {
    logic [2:0]  sentence_kind;
    logic [4:0]  field_index;
    logic [31:0] field_value;
    logic [2:0]  frac_digits;
    logic [7:0]  first_char;
    logic        is_last;
  } res_t;

  function automatic logic [2:0] classify(input logic [39:0] h);
    logic [2:0] k;
    k = KIND_OTHER;
    if (h == HDR_GPGSV) k = KIND_GSV;
    else if (h == HDR_GPGGA) k = KIND_GGA;
    else if (h == HDR_GPGSA) k = KIND_GSA;
    else if (h == HDR_GPRMC) k = KIND_RMC;
    else if (h == HDR_GPVTG) k = KIND_VTG;
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nsfp_parse.sv =====
`default_nettype none
module nsfp_parse (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step_en,
  input  wire logic [7:0]    step_byte,
  output nsfp_pkg::res_t     res,
  output logic               res_valid
);
  import nsfp_pkg::*;

  logic        in_sentence, in_sentence_next;
  logic        in_header, in_header_next;
  logic [39:0] header_chars, header_chars_next;
  logic [2:0]  hdr_cnt, hdr_cnt_next;
  logic [4:0]  field_count, field_count_next;
  logic [31:0] accumulator, accumulator_next;
  logic [2:0]  frac_count, frac_count_next;
  logic        seen_point, seen_point_next;
  logic        negative, negative_next;
  logic        field_bad, field_bad_next;
  logic [7:0]  field_first, field_first_next;
  logic [2:0]  kind_code, kind_code_next;

  logic [31:0] acc_step;
  logic [31:0] digit;
  logic        is_digit;

  assign digit    = {24'd0, step_byte - CH_ZERO};
  assign is_digit = (step_byte >= CH_ZERO) && (step_byte <= CH_NINE);
  assign acc_step = (accumulator << 3) + (accumulator << 1) + digit;

  always_comb begin
    in_sentence_next  = in_sentence;
    in_header_next    = in_header;
    header_chars_next = header_chars;
    hdr_cnt_next      = hdr_cnt;
    field_count_next  = field_count;
    accumulator_next  = accumulator;
    frac_count_next   = frac_count;
    seen_point_next   = seen_point;
    negative_next     = negative;
    field_bad_next    = field_bad;
    field_first_next  = field_first;
    kind_code_next    = kind_code;
    res_valid         = 1'b0;
    res.sentence_kind = kind_code;
    res.field_index   = field_count;
    res.field_value   = 32'd0;
    res.frac_digits   = 3'd0;
    res.first_char    = field_first;
    res.is_last       = (step_byte == CH_STAR);

    if (field_count < 5'(MAX_FIELD_INDEX)) begin
      res.field_index = field_count + 5'd1;
    end
    if (!field_bad) begin
      res.field_value = negative ? (32'd0 - accumulator) : accumulator;
      res.frac_digits = frac_count;
    end

    if (step_en) begin
      if (step_byte == CH_DOLLAR) begin
        in_sentence_next  = 1'b1;
        in_header_next    = 1'b1;
        header_chars_next = 40'd0;
        hdr_cnt_next      = 3'd0;
        field_count_next  = 5'd0;
        kind_code_next    = KIND_OTHER;
        accumulator_next  = 32'd0;
        frac_count_next   = 3'd0;
        seen_point_next   = 1'b0;
        negative_next     = 1'b0;
        field_bad_next    = 1'b0;
        field_first_next  = 8'd0;
      end else if (in_sentence) begin
        if (step_byte < CH_SPACE || step_byte > CH_LOW_Z) begin
          in_sentence_next = 1'b0;
          in_header_next   = 1'b0;
        end else if (in_header) begin
          if (step_byte == CH_COMMA) begin
            kind_code_next   = classify(header_chars);
            in_header_next   = 1'b0;
            accumulator_next = 32'd0;
            frac_count_next  = 3'd0;
            seen_point_next  = 1'b0;
            negative_next    = 1'b0;
            field_bad_next   = 1'b0;
            field_first_next = 8'd0;
          end else if (step_byte == CH_STAR) begin
            in_sentence_next = 1'b0;
            in_header_next   = 1'b0;
          end else if (hdr_cnt < 3'(HDR_LEN)) begin
            // header bytes are never zero, so the fill count marks the free slot
            header_chars_next = header_chars |
                                ({32'd0, step_byte} << (6'd8 * (6'(HDR_LEN - 1) - 6'(hdr_cnt))));
            hdr_cnt_next = hdr_cnt + 3'd1;
          end
        end else if (step_byte == CH_COMMA || step_byte == CH_STAR) begin
          res_valid        = 1'b1;
          field_count_next = res.field_index;
          accumulator_next = 32'd0;
          frac_count_next  = 3'd0;
          seen_point_next  = 1'b0;
          negative_next    = 1'b0;
          field_bad_next   = 1'b0;
          field_first_next = 8'd0;
          if (step_byte == CH_STAR) begin
            in_sentence_next = 1'b0;
          end
        end else begin
          if (field_first == 8'd0) begin
            field_first_next = step_byte;
          end
          if (step_byte == CH_MINUS) begin
            negative_next = 1'b1;
          end else if (step_byte == CH_POINT) begin
            if (seen_point) begin
              field_bad_next = 1'b1;
            end else begin
              seen_point_next = 1'b1;
            end
          end else if (is_digit) begin
            if (!seen_point) begin
              accumulator_next = acc_step;
            end else if (frac_count < 3'(MAX_FRAC_DIGITS)) begin
              accumulator_next = acc_step;
              frac_count_next  = frac_count + 3'd1;
            end
          end else begin
            field_bad_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence  <= 1'b0;
      in_header    <= 1'b0;
      header_chars <= 40'd0;
      hdr_cnt      <= 3'd0;
      field_count  <= 5'd0;
      accumulator  <= 32'd0;
      frac_count   <= 3'd0;
      seen_point   <= 1'b0;
      negative     <= 1'b0;
      field_bad    <= 1'b0;
      field_first  <= 8'd0;
      kind_code    <= KIND_OTHER;
    end else begin
      in_sentence  <= in_sentence_next;
      in_header    <= in_header_next;
      header_chars <= header_chars_next;
      hdr_cnt      <= hdr_cnt_next;
      field_count  <= field_count_next;
      accumulator  <= accumulator_next;
      frac_count   <= frac_count_next;
      seen_point   <= seen_point_next;
      negative     <= negative_next;
      field_bad    <= field_bad_next;
      field_first  <= field_first_next;
      kind_code    <= kind_code_next;
    end
  end

  a_res_needs_step: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (step_en && in_sentence && !in_header))
    else $error("field result without a step in a sentence body");
  a_header_in_sentence: assert property (@(posedge clk) disable iff (rst)
    in_header |-> in_sentence)
    else $error("header state outside a sentence");
  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    frac_count <= 3'(MAX_FRAC_DIGITS))
    else $error("fraction digit count out of range");
  a_star_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.is_last) |=> !in_sentence)
    else $error("sentence still open after last field");

endmodule
`default_nettype wire

// ===== hw/rtl/nsfp_out_reg.sv =====
`default_nettype none
module nsfp_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire nsfp_pkg::res_t res,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [2:0]         sentence_kind,
  output logic [4:0]         field_index,
  output logic signed [31:0] field_value,
  output logic [2:0]         frac_digits,
  output logic [7:0]         first_char,
  output logic               is_last
);
  import nsfp_pkg::*;

  res_t held;
  logic out_valid_next;

  assign out_valid_next = load | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign sentence_kind = held.sentence_kind;
  assign field_index   = held.field_index;
  assign field_value   = signed'(held.field_value);
  assign frac_digits   = held.frac_digits;
  assign first_char    = held.first_char;
  assign is_last       = held.is_last;

endmodule
`default_nettype wire

// ===== hw/rtl/nmea_sentence_field_parser_core.sv =====
// a field result is loaded into the output register when its terminator byte leaves the input register
// throughput: one byte per cycle while the output is not stalled; the parse state loop updates once per byte
// a byte waits in the input register only while the output register holds an untaken item
// reset (rst, synchronous, active high) clears valids and returns the parser to idle,
// waiting for a dollar sign, with sentence kind other
`default_nettype none
module nmea_sentence_field_parser_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    byte_in,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         sentence_kind,
  output logic [4:0]         field_index,
  output logic signed [31:0] field_value,
  output logic [2:0]         frac_digits,
  output logic [7:0]         first_char,
  output logic               is_last
);
  import nsfp_pkg::*;

  logic       s1_valid, s1_valid_next;
  logic [7:0] s1_byte;
  logic       adv;
  logic       in_take;
  res_t       res;
  logic       res_valid;

  assign adv      = s1_valid & ~(out_valid & out_stall);
  assign in_stall = s1_valid & out_valid & out_stall;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_take) begin
      s1_valid_next = 1'b1;
    end else if (adv) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= byte_in;
    end
  end

  nsfp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step_en   (adv),
    .step_byte (s1_byte),
    .res       (res),
    .res_valid (res_valid)
  );

  nsfp_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (res_valid),
    .res           (res),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .sentence_kind (sentence_kind),
    .field_index   (field_index),
    .field_value   (field_value),
    .frac_digits   (frac_digits),
    .first_char    (first_char),
    .is_last       (is_last)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with room downstream");
  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_byte)))
    else $error("waiting byte lost");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(out_valid && out_stall))
    else $error("result loaded over an untaken item");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
  import nsfp_pkg::*;

  localparam int ITEMS = 2000;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       fixed;
    res_t       want;
  } dir_row_t;

  localparam res_t NO_RES = '0;
  localparam int DIR_LEN = 23;

  // byte, fixed expectation flag, expected field
  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    {8'h00,     1'b0, NO_RES},
    {CH_DOLLAR, 1'b0, NO_RES},
    {8'hFF,     1'b0, NO_RES},
    {CH_DOLLAR, 1'b0, NO_RES},
    {"G",       1'b0, NO_RES},
    {CH_STAR,   1'b0, NO_RES},
    {CH_DOLLAR, 1'b0, NO_RES},
    {"A",       1'b0, NO_RES},
    {CH_COMMA,  1'b0, NO_RES},
    {"1",       1'b0, NO_RES},
    {CH_POINT,  1'b0, NO_RES},
    {CH_STAR,   1'b1, KIND_OTHER, 5'd1, 32'd1, 3'd0, "1", 1'b1},
    {CH_DOLLAR, 1'b0, NO_RES},
    {CH_COMMA,  1'b0, NO_RES},
    {CH_MINUS,  1'b0, NO_RES},
    {CH_ZERO,   1'b0, NO_RES},
    {CH_COMMA,  1'b1, KIND_OTHER, 5'd1, 32'd0, 3'd0, CH_MINUS, 1'b0},
    {"x",       1'b0, NO_RES},
    {CH_COMMA,  1'b1, KIND_OTHER, 5'd2, 32'd0, 3'd0, "x", 1'b0},
    {CH_NINE,   1'b0, NO_RES},
    {CH_POINT,  1'b0, NO_RES},
    {CH_POINT,  1'b0, NO_RES},
    {CH_STAR,   1'b1, KIND_OTHER, 5'd3, 32'd0, 3'd0, CH_NINE, 1'b1}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  byte_in = 8'h00;
  logic        out_stall = 1'b0;
  wire logic   in_stall;
  wire logic   out_valid;
  wire logic [2:0]  sentence_kind;
  wire logic [4:0]  field_index;
  wire logic [31:0] field_value;
  wire logic [2:0]  frac_digits;
  wire logic [7:0]  first_char;
  wire logic        is_last;

  nmea_sentence_field_parser_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_in       (byte_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sentence_kind (sentence_kind),
    .field_index   (field_index),
    .field_value   (field_value),
    .frac_digits   (frac_digits),
    .first_char    (first_char),
    .is_last       (is_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // parser state of the predictor
  logic        p_in_sent = 1'b0;
  logic        p_in_hdr = 1'b0;
  logic [39:0] p_hdr = '0;
  logic [4:0]  p_fcount = '0;
  logic [31:0] p_acc = '0;
  logic [2:0]  p_frac = '0;
  logic        p_seen_pt = 1'b0;
  logic        p_neg = 1'b0;
  logic        p_bad = 1'b0;
  logic [7:0]  p_first = '0;
  logic [2:0]  p_kind = KIND_OTHER;

  res_t expected_fields [$];
  int   mismatches = 0;
  int   live_items = 0;
  int   burst_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic clear_field();
    p_acc = '0;
    p_frac = '0;
    p_seen_pt = 1'b0;
    p_neg = 1'b0;
    p_bad = 1'b0;
    p_first = '0;
  endtask

  task automatic parse_nmea_byte(input logic [7:0] b, output bit got, output res_t r);
    bit placed;
    got = 1'b0;
    r = '0;
    placed = 1'b0;
    if (b == CH_DOLLAR) begin
      p_in_sent = 1'b1;
      p_in_hdr = 1'b1;
      p_hdr = '0;
      p_fcount = '0;
      p_kind = KIND_OTHER;
      clear_field();
    end else if (!p_in_sent) begin
      // idle, waiting for a dollar sign
    end else if (b < CH_SPACE || b > CH_LOW_Z) begin
      p_in_sent = 1'b0;
      p_in_hdr = 1'b0;
    end else if (p_in_hdr) begin
      if (b == CH_COMMA) begin
        case (p_hdr)
          HDR_GPGSV: p_kind = KIND_GSV;
          HDR_GPGGA: p_kind = KIND_GGA;
          HDR_GPGSA: p_kind = KIND_GSA;
          HDR_GPRMC: p_kind = KIND_RMC;
          HDR_GPVTG: p_kind = KIND_VTG;
          default:   p_kind = KIND_OTHER;
        endcase
        p_in_hdr = 1'b0;
        clear_field();
      end else if (b == CH_STAR) begin
        p_in_sent = 1'b0;
        p_in_hdr = 1'b0;
      end else begin
        for (int i = HDR_LEN - 1; i >= 0; i--) begin
          if (!placed && p_hdr[8*i +: 8] == 8'h00) begin
            p_hdr[8*i +: 8] = b;
            placed = 1'b1;
          end
        end
      end
    end else if (b == CH_COMMA || b == CH_STAR) begin
      if (p_fcount < MAX_FIELD_INDEX) p_fcount++;
      got = 1'b1;
      r.sentence_kind = p_kind;
      r.field_index = p_fcount;
      r.field_value = p_bad ? 32'd0 : (p_neg ? -p_acc : p_acc);
      r.frac_digits = p_bad ? 3'd0 : p_frac;
      r.first_char = p_first;
      r.is_last = (b == CH_STAR);
      clear_field();
      if (b == CH_STAR) p_in_sent = 1'b0;
    end else begin
      if (p_first == 8'h00) p_first = b;
      if (b == CH_MINUS) begin
        p_neg = 1'b1;
      end else if (b == CH_POINT) begin
        if (p_seen_pt) p_bad = 1'b1;
        else p_seen_pt = 1'b1;
      end else if (b >= CH_ZERO && b <= CH_NINE) begin
        if (!p_seen_pt || p_frac < MAX_FRAC_DIGITS) begin
          p_acc = p_acc * 32'd10 + {24'd0, b - CH_ZERO};
          if (p_seen_pt) p_frac++;
        end
      end else begin
        p_bad = 1'b1;
      end
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic fixed, input res_t want);
    int gap;
    bit got;
    res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    byte_in <= b;
    do @(posedge clk); while (in_stall);
    live_items++;
    parse_nmea_byte(b, got, r);
    if (fixed) expected_fields.push_back(want);
    else if (got) expected_fields.push_back(r);
    @(negedge clk);
  endtask

  task automatic put(input logic [7:0] b);
    send_byte(b, 1'b0, NO_RES);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) put(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] rand_char(input bit in_field);
    logic [7:0] c;
    do c = 8'($urandom_range(CH_SPACE, CH_LOW_Z));
    while (c == CH_COMMA || c == CH_STAR || c == CH_DOLLAR ||
           (in_field && (c == CH_MINUS || c == CH_POINT ||
                         (c >= CH_ZERO && c <= CH_NINE))));
    return c;
  endfunction

  task automatic gen_field();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      // empty field
    end else if (pick <= 10) begin
      if ($urandom_range(0, 3) == 0) put(CH_MINUS);
      put_digits($urandom_range(0, 6));
      if ($urandom_range(0, 1) == 1) begin
        put(CH_POINT);
        put_digits($urandom_range(0, 8));
      end
    end else if (pick <= 12) begin
      // long run of digits, wraps
      if ($urandom_range(0, 1) == 1) put(CH_MINUS);
      put_digits($urandom_range(10, 14));
    end else if (pick <= 14) begin
      put(rand_char(1'b1));
      put_digits($urandom_range(0, 2));
    end else if (pick == 15) begin
      put_digits($urandom_range(0, 2));
      put(CH_POINT);
      put_digits($urandom_range(0, 2));
      put(CH_POINT);
      put_digits($urandom_range(0, 2));
    end else if (pick == 16) begin
      put_digits($urandom_range(1, 3));
      put(CH_MINUS);
      put_digits($urandom_range(1, 3));
    end else if (pick == 17) begin
      put_digits($urandom_range(0, 3));
      put(rand_char(1'b1));
      put_digits($urandom_range(0, 3));
    end else if (pick == 18) begin
      send_text("99999.999999999");
    end else begin
      // broken field: abort or restart
      case ($urandom_range(0, 2))
        0: put(8'($urandom_range(0, 31)));
        1: put(8'($urandom_range(8'h7B, 8'hFF)));
        default: put(CH_DOLLAR);
      endcase
    end
  endtask

  task automatic gen_sentence();
    int nf;
    put(CH_DOLLAR);
    case ($urandom_range(0, 9))
      0: send_text("GPGSV");
      1: send_text("GPGGA");
      2: send_text("GPGSA");
      3: send_text("GPRMC");
      4: send_text("GPVTG");
      5: begin
        send_text("GPRMC");
        put(rand_char(1'b0));
      end
      6: begin
        send_text("GPGS");
        put(8'($urandom_range("A", "Z")));
      end
      7: repeat ($urandom_range(0, 7)) put(rand_char(1'b0));
      8: send_text("GNGGA");
      default: begin
        repeat ($urandom_range(0, 4)) put(rand_char(1'b0));
        put(CH_STAR);
      end
    endcase
    put(CH_COMMA);
    nf = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 12);
    for (int i = 0; i < nf; i++) begin
      gen_field();
      if (i == nf - 1 && $urandom_range(0, 14) == 0) begin
        // sentence left open
      end else begin
        put((i == nf - 1) ? CH_STAR : CH_COMMA);
      end
    end
    put(CH_ZERO + 8'($urandom_range(0, 9)));
    put(8'($urandom_range("A", "F")));
    put(8'h0D);
    put(8'h0A);
  endtask

  // receiver stall pattern
  initial begin
    int cyc;
    int mode;
    int run_left;
    logic run_val;
    cyc = 0;
    mode = 0;
    run_left = 0;
    run_val = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: begin
          if (run_left == 0) begin
            run_left = $urandom_range(1, 16);
            run_val = ~run_val;
          end
          run_left--;
          out_stall <= run_val;
        end
        default: out_stall <= cyc[1];
      endcase
    end
  end

  // result checker
  initial begin
    res_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_fields.size() == 0) begin
          report_mismatch("unexpected field", field_value, 32'd0);
        end else begin
          want = expected_fields.pop_front();
          if (sentence_kind !== want.sentence_kind)
            report_mismatch("sentence_kind", 32'(sentence_kind), 32'(want.sentence_kind));
          if (field_index !== want.field_index)
            report_mismatch("field_index", 32'(field_index), 32'(want.field_index));
          if (field_value !== want.field_value)
            report_mismatch("field_value", field_value, want.field_value);
          if (frac_digits !== want.frac_digits)
            report_mismatch("frac_digits", 32'(frac_digits), 32'(want.frac_digits));
          if (first_char !== want.first_char)
            report_mismatch("first_char", 32'(first_char), 32'(want.first_char));
          if (is_last !== want.is_last)
            report_mismatch("is_last", 32'(is_last), 32'(want.is_last));
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_LEN; i++)
      send_byte(DIR_ROWS[i].ch, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
    live_items = 0;
    while (live_items < ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)));
      end else begin
        gen_sentence();
      end
    end
    in_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
